[hdl/sorted_table_binary_search_top_macros.svh]
// ----------------------------------------------------------------------------
// Sorted table binary search: assertion macros
// Shared assertion forms. Each expects clk and rst in the using scope.
// ----------------------------------------------------------------------------
`ifndef SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH
`define SORTED_TABLE_BINARY_SEARCH_TOP_MACROS_SVH

// same-cycle implication
`define STBS_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("stbs: same-cycle check failed");

// next-cycle implication
`define STBS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("stbs: next-cycle check failed");

`endif

[hdl/stbs_pkg.sv]
// ----------------------------------------------------------------------------
// stbs_pkg
// Widths, defaults and controller/datapath interface types.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int DATA_W          = 64;
  localparam int LEN_W           = 13;
  localparam int IDX_W           = 12;

  // request codes on req_type
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  // controller -> datapath
  typedef struct packed {
    logic wr;       // store the accepted write request
    logic start;    // load key and initial window
    logic probe;    // register midpoint, issue table read
    logic compare;  // apply compare result to window
    logic finish;   // load output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic empty;    // window holds no entries
    logic eq;       // probed entry equals key
    logic out_busy; // output register full and stalled
  } status_t;

endpackage

[hdl/stbs_ram.sv]
// ----------------------------------------------------------------------------
// stbs_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module stbs_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4096,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/stbs_dp.sv]
// ----------------------------------------------------------------------------
// stbs_dp
// Datapath: length register, table memory, search window, output register.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_top_macros.svh"

module stbs_dp #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [stbs_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic [stbs_pkg::IDX_W-1:0]   entry_index,
  input  logic [stbs_pkg::DATA_W-1:0]  entry_value,
  input  logic [stbs_pkg::DATA_W-1:0]  search_key,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         found,
  output logic [stbs_pkg::IDX_W-1:0]   found_index,
  input  stbs_pkg::cmd_t               cmd,
  output stbs_pkg::status_t            st
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  // window width: holds the depth itself and any length value
  localparam int PW = (AW + 1 > stbs_pkg::LEN_W) ? AW + 1 : stbs_pkg::LEN_W;
  localparam logic [PW-1:0] DEPTH_P = PW'(TABLE_DEPTH);

  logic [stbs_pkg::LEN_W-1:0]  table_length;
  logic [stbs_pkg::DATA_W-1:0] key;
  logic [PW-1:0]               lo;
  logic [PW-1:0]               end_q;   // exclusive upper bound
  logic [PW-1:0]               mid_q;
  logic                        hit;
  logic [PW-1:0]               len_ext;
  logic [PW-1:0]               len_sat;
  logic [PW-1:0]               idx_ext;
  logic [PW-1:0]               mid;
  logic [stbs_pkg::DATA_W-1:0] rd_data;
  logic                        wr_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      table_length <= '0;
    end else if (cfg_we) begin
      table_length <= cfg_wdata;
    end
  end

  assign len_ext = PW'(table_length);
  assign len_sat = (len_ext > DEPTH_P) ? DEPTH_P : len_ext;
  assign idx_ext = PW'(entry_index);
  assign wr_ok   = cmd.wr && (idx_ext < DEPTH_P);

  // floored midpoint of [lo, end_q-1]
  assign mid = lo + ((end_q - lo - PW'(1)) >> 1);

  stbs_ram #(
    .WIDTH (stbs_pkg::DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (wr_ok),
    .waddr (idx_ext[AW-1:0]),
    .wdata (entry_value),
    .re    (cmd.probe),
    .raddr (mid[AW-1:0]),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      lo    <= '0;
      end_q <= '0;
      hit   <= 1'b0;
    end else if (cmd.start) begin
      lo    <= '0;
      end_q <= len_sat;
      hit   <= 1'b0;
    end else if (cmd.compare) begin
      if (st.eq) begin
        hit <= 1'b1;
      end else if ($signed(rd_data) < $signed(key)) begin
        lo <= mid_q + PW'(1);
      end else begin
        end_q <= mid_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key <= search_key;
    end
    if (cmd.probe) begin
      mid_q <= mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found       <= hit;
      found_index <= hit ? mid_q[stbs_pkg::IDX_W-1:0] : '0;
    end
  end

  assign st.empty    = !(lo < end_q);
  assign st.eq       = (rd_data == key);
  assign st.out_busy = out_valid && !out_ready;

  `STBS_ASSERT_SAME(a_window_order, 1'b1, lo <= end_q)
  `STBS_ASSERT_SAME(a_probe_in_window, cmd.probe, mid < end_q && mid >= lo)
  `STBS_ASSERT_NEXT(a_finish_loads, cmd.finish, out_valid)
  `STBS_ASSERT_SAME(a_miss_index_zero, out_valid && !found, found_index == '0)

endmodule

[hdl/stbs_ctrl.sv]
// ----------------------------------------------------------------------------
// stbs_ctrl
// Controller: sequences table writes and the probe/compare loop of a search.
// ----------------------------------------------------------------------------
`include "sorted_table_binary_search_top_macros.svh"

module stbs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               req_type,
  output stbs_pkg::cmd_t     cmd,
  input  stbs_pkg::status_t  st
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_CHECK  = 2'd1;
  localparam logic [1:0] S_CMP    = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       is_search;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign is_search = (req_type == stbs_pkg::REQ_SEARCH);

  always_comb begin
    state_next  = state;
    cmd         = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (is_search) begin
            cmd.start  = 1'b1;
            state_next = S_CHECK;
          end else begin
            cmd.wr = 1'b1;
          end
        end
      end
      S_CHECK: begin
        if (st.empty) begin
          state_next = S_FINISH;
        end else begin
          cmd.probe  = 1'b1;
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        cmd.compare = 1'b1;
        state_next  = st.eq ? S_FINISH : S_CHECK;
      end
      S_FINISH: begin
        if (!st.out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `STBS_ASSERT_NEXT(a_search_starts, accept && is_search, state == S_CHECK)
  `STBS_ASSERT_NEXT(a_write_stays_idle, accept && !is_search, state == S_IDLE)
  `STBS_ASSERT_NEXT(a_hit_ends_search, state == S_CMP && st.eq, state == S_FINISH)
  `STBS_ASSERT_NEXT(a_finish_holds, state == S_FINISH && st.out_busy, state == S_FINISH)

endmodule

[hdl/sorted_table_binary_search_top.sv]
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top
// Sorted table of signed 64-bit entries with a binary search request.
//
// Input channel (in_valid/in_ready): req_type 0 writes entry_value at
// entry_index (ignored at or beyond TABLE_DEPTH) and returns nothing;
// req_type 1 searches for search_key over entries 0 .. table_length-1
// (length clamped to TABLE_DEPTH) and returns one result.
// Output channel (out_valid/out_ready): found and found_index, index 0 on miss.
// cfg_we/cfg_wdata load table_length; write it only while idle.
// A write request is stored as it is accepted. A search holds the input
// through a read and a compare state per probe (split by the registered RAM
// read) and a finish state that loads the output register, with at most 13
// probes over 4096 entries; a miss ends when the window is empty.
// A finished result sits in an output register; a new request is taken while
// it waits, but the next search result stalls in the controller until the
// receiver takes the pending one.
// Reset clears table_length and the handshake state; table contents are
// not cleared and must be written before they are searched.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top #(
  parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [stbs_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         req_type,
  input  logic [stbs_pkg::IDX_W-1:0]   entry_index,
  input  logic [stbs_pkg::DATA_W-1:0]  entry_value,
  input  logic [stbs_pkg::DATA_W-1:0]  search_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         found,
  output logic [stbs_pkg::IDX_W-1:0]   found_index
);

  stbs_pkg::cmd_t    cmd;
  stbs_pkg::status_t st;

  stbs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .req_type (req_type),
    .cmd      (cmd),
    .st       (st)
  );

  stbs_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .out_ready   (out_ready),
    .out_valid   (out_valid),
    .found       (found),
    .found_index (found_index),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

[tb/sorted_table_binary_search_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_binary_search_top_tb
// Fills the low part of the table and the entries probed by searches for the
// extremes in ascending order, then runs a short table of directed requests
// and about 600 random write and search requests over several length
// settings and idle patterns. Untyped search results are checked against a
// binary search over the local table copy; typed ones match a given result.
// ----------------------------------------------------------------------------
module sorted_table_binary_search_top_tb;

  localparam int DEPTH    = stbs_pkg::TABLE_DEPTH_DEF;
  // random searches stay inside this prefix, which is always written
  localparam int FILL_LEN = 256;

  typedef logic signed [stbs_pkg::DATA_W-1:0] word_t;
  typedef logic [stbs_pkg::IDX_W-1:0]         idx_t;
  typedef logic [stbs_pkg::LEN_W-1:0]         len_t;

  localparam word_t WORD_MIN   = 64'sh8000_0000_0000_0000;
  localparam word_t WORD_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam word_t NEG_2P62   = 64'shC000_0000_0000_0000;
  localparam word_t POS_2P52   = 64'sh0010_0000_0000_0000;
  localparam word_t ALL_ONES   = -64'sd1;

  localparam int SEND_IDLE_PCT [4] = '{0, 53, 0, 20};
  localparam int RECV_STALL_PCT[4] = '{0, 0, 53, 20};

  typedef struct packed {
    logic found;
    idx_t index;
  } result_t;

  typedef enum logic {ROW_CFG, ROW_REQ} row_kind_t;

  typedef struct {
    row_kind_t kind;
    len_t      len;
    logic      rt;
    idx_t      idx;
    word_t     val;
    word_t     key;
    bit        typed;
    result_t   res;
  } row_t;

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          cfg_we;
  len_t                          cfg_wdata;
  logic                          in_valid;
  logic                          in_ready;
  logic                          req_type;
  idx_t                          entry_index;
  logic [stbs_pkg::DATA_W-1:0]   entry_value;
  logic [stbs_pkg::DATA_W-1:0]   search_key;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          found;
  idx_t                          found_index;

  word_t            table_model [DEPTH];
  len_t             len_model;
  result_t          pending_results[$];
  int               send_idle_pct;
  int               stall_pct;
  int               mismatch_count;

  sorted_table_binary_search_top dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .entry_index (entry_index),
    .entry_value (entry_value),
    .search_key  (search_key),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .found_index (found_index)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Binary search over the local table copy; length saturates at the depth.
  function automatic result_t bsearch_predict(word_t key);
    int      lo;
    int      hi;
    int      mid;
    result_t r;
    r  = '0;
    lo = 0;
    hi = ((len_model > DEPTH) ? DEPTH : int'(len_model)) - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (table_model[mid] == key) begin
        r.found = 1'b1;
        r.index = idx_t'(mid);
        return r;
      end else if (table_model[mid] < key) begin
        lo = mid + 1;
      end else begin
        hi = mid - 1;
      end
    end
    return r;
  endfunction

  // Ascending fill with equal pairs; the ends hold the extremes.
  function automatic word_t fill_value(int i);
    if (i == 0) return WORD_MIN;
    if (i == DEPTH - 1) return WORD_MAX;
    return word_t'((longint'(i / 2) - 1024) * longint'(POS_2P52));
  endfunction

  function automatic row_t cfg_row(len_t len);
    row_t r;
    r.kind  = ROW_CFG;
    r.len   = len;
    r.rt    = stbs_pkg::REQ_WRITE;
    r.idx   = '0;
    r.val   = '0;
    r.key   = '0;
    r.typed = 1'b0;
    r.res   = '0;
    return r;
  endfunction

  function automatic row_t wr_row(idx_t idx, word_t val);
    row_t r;
    r       = cfg_row('0);
    r.kind  = ROW_REQ;
    r.rt    = stbs_pkg::REQ_WRITE;
    r.idx   = idx;
    r.val   = val;
    return r;
  endfunction

  function automatic row_t srch_row(word_t key, bit typed, logic f, idx_t i);
    row_t r;
    r       = cfg_row('0);
    r.kind  = ROW_REQ;
    r.rt    = stbs_pkg::REQ_SEARCH;
    r.key   = key;
    r.typed = typed;
    r.res   = '{found: f, index: i};
    return r;
  endfunction

  // Enter and leave at a falling edge; valid stays up after acceptance
  // until the next request or a drain lowers it.
  task automatic send_req(input logic rt, input idx_t idx, input word_t val,
                          input word_t key, input bit typed, input result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid    = 1'b1;
    req_type    = rt;
    entry_index = idx;
    entry_value = val;
    search_key  = key;
    do @(posedge clk); while (!in_ready);
    if (rt == stbs_pkg::REQ_WRITE) table_model[idx] = val;
    else if (typed) pending_results.push_back(want);
    else pending_results.push_back(bsearch_predict(key));
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // a write request may still be in flight
    repeat (4) @(negedge clk);
  endtask

  task automatic set_length(input len_t len);
    wait_drained();
    cfg_we    = 1'b1;
    cfg_wdata = len;
    @(negedge clk);
    cfg_we    = 1'b0;
    len_model = len;
  endtask

  function automatic len_t pick_length();
    case ($urandom_range(9))
      0:       return len_t'($urandom_range(3));
      1:       return len_t'(FILL_LEN);
      default: return len_t'($urandom_range(FILL_LEN, 1));
    endcase
  endfunction

  // Mostly order-keeping writes and keys taken from the table, some noise.
  task automatic random_item();
    int               eff;
    int               i;
    int               pick;
    word_t            key;
    word_t            val;
    word_t            lo_v;
    word_t            hi_v;
    logic [63:0]      span;
    logic [63:0]      r64;
    idx_t             idx;
    eff = (len_model > DEPTH) ? DEPTH : int'(len_model);
    r64 = {$urandom, $urandom};
    if ($urandom_range(99) < 60) begin
      key = r64;
      if (eff > 0) begin
        i    = $urandom_range(eff - 1);
        pick = $urandom_range(9);
        if (pick < 5) key = table_model[i];
        else if (pick == 5) key = table_model[i] + 1;
        else if (pick == 6) key = table_model[i] - 1;
      end
      send_req(stbs_pkg::REQ_SEARCH, idx_t'($urandom), {$urandom, $urandom}, key, 1'b0,
               '0);
    end else begin
      if (eff > 0 && $urandom_range(9) < 7) idx = idx_t'($urandom_range(eff - 1));
      else idx = idx_t'($urandom);
      lo_v = (idx == 0) ? WORD_MIN : table_model[idx - 1];
      hi_v = (idx == DEPTH - 1) ? WORD_MAX : table_model[idx + 1];
      val  = r64;
      if ($urandom_range(9) < 8 && hi_v >= lo_v) begin
        span = hi_v - lo_v;
        if (span != '1) val = lo_v + r64 % (span + 1);
      end
      send_req(stbs_pkg::REQ_WRITE, idx, val, {$urandom, $urandom}, 1'b0, '0);
    end
  endtask

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: found %0d, found_index %0d", found, found_index);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, found);
          mismatch_count++;
        end
        if (found_index !== want.index) begin
          $error("found_index: expected %0d, actual %0d", want.index, found_index);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    row_t dir_rows[$];
    int   lo;
    int   hi;
    int   mid;
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_valid       = 1'b0;
    req_type       = stbs_pkg::REQ_WRITE;
    entry_index    = '0;
    entry_value    = '0;
    search_key     = '0;
    len_model      = '0;
    send_idle_pct  = 0;
    stall_pct      = 0;
    mismatch_count = 0;

    // zero length straight after reset, then the extremes and wrong order
    dir_rows.push_back(srch_row(64'sd5, 1'b1, 1'b0, '0));
    dir_rows.push_back(cfg_row(13'd1));
    dir_rows.push_back(srch_row(WORD_MIN, 1'b1, 1'b1, '0));
    dir_rows.push_back(srch_row(WORD_MAX, 1'b1, 1'b0, '0));
    dir_rows.push_back(cfg_row(len_t'(DEPTH)));
    dir_rows.push_back(srch_row(WORD_MIN, 1'b1, 1'b1, '0));
    dir_rows.push_back(srch_row(WORD_MAX, 1'b1, 1'b1, idx_t'(DEPTH - 1)));
    dir_rows.push_back(cfg_row(13'd8191));
    dir_rows.push_back(srch_row(WORD_MAX, 1'b1, 1'b1, idx_t'(DEPTH - 1)));
    dir_rows.push_back(srch_row(WORD_MIN, 1'b1, 1'b1, '0));
    dir_rows.push_back(cfg_row(len_t'(DEPTH + 1)));
    dir_rows.push_back(srch_row(WORD_MIN, 1'b1, 1'b1, '0));
    dir_rows.push_back(cfg_row(13'd2));
    dir_rows.push_back(srch_row(NEG_2P62, 1'b1, 1'b1, 12'd1));
    dir_rows.push_back(cfg_row(len_t'(FILL_LEN)));
    dir_rows.push_back(srch_row(64'sd0, 1'b0, 1'b0, '0));
    dir_rows.push_back(srch_row(64'sd1, 1'b0, 1'b0, '0));
    dir_rows.push_back(srch_row(ALL_ONES, 1'b0, 1'b0, '0));
    dir_rows.push_back(srch_row(POS_2P52, 1'b0, 1'b0, '0));
    dir_rows.push_back(srch_row(fill_value(FILL_LEN / 2), 1'b0, 1'b0, '0));
    dir_rows.push_back(wr_row(idx_t'(DEPTH - 1), WORD_MIN));
    dir_rows.push_back(cfg_row(len_t'(DEPTH)));
    dir_rows.push_back(srch_row(WORD_MAX, 1'b1, 1'b0, '0));
    dir_rows.push_back(wr_row(idx_t'(DEPTH - 1), WORD_MAX));
    dir_rows.push_back(wr_row('0, ALL_ONES));
    dir_rows.push_back(cfg_row(len_t'(FILL_LEN)));
    dir_rows.push_back(srch_row(ALL_ONES, 1'b0, 1'b0, '0));
    dir_rows.push_back(wr_row('0, WORD_MIN));
    dir_rows.push_back(cfg_row(13'd0));
    dir_rows.push_back(srch_row(WORD_MAX, 1'b1, 1'b0, '0));

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // every entry is written before any search can probe it
    for (int i = 0; i < FILL_LEN; i++) begin
      send_req(stbs_pkg::REQ_WRITE, idx_t'(i), fill_value(i), {$urandom, $urandom}, 1'b0,
               '0);
    end
    // entries probed by searches for the extremes over the full table
    lo = 0;
    hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mid >= FILL_LEN) begin
        send_req(stbs_pkg::REQ_WRITE, idx_t'(mid), fill_value(mid), {$urandom, $urandom},
                 1'b0, '0);
      end
      hi = mid - 1;
    end
    lo = (DEPTH - 1) / 2 + 1;
    hi = DEPTH - 1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (mid >= FILL_LEN) begin
        send_req(stbs_pkg::REQ_WRITE, idx_t'(mid), fill_value(mid), {$urandom, $urandom},
                 1'b0, '0);
      end
      lo = mid + 1;
    end

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        set_length(dir_rows[k].len);
      end else begin
        send_req(dir_rows[k].rt, dir_rows[k].idx, dir_rows[k].val, dir_rows[k].key,
                 dir_rows[k].typed, dir_rows[k].res);
      end
    end

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = SEND_IDLE_PCT[p];
      stall_pct     = RECV_STALL_PCT[p];
      for (int s = 0; s < 5; s++) begin
        set_length(pick_length());
        repeat (30) random_item();
      end
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/stbs_pkg.sv
hdl/stbs_ram.sv
hdl/stbs_dp.sv
hdl/stbs_ctrl.sv
hdl/sorted_table_binary_search_top.sv
tb/sorted_table_binary_search_top_tb.sv
